FILE: rtl/bbrm_pkg.sv
// ----------------------------------------------------------------------------
// bbrm_pkg
// Shared types and constants of the bip buffer region manager: port widths,
// request opcodes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package bbrm_pkg;

    // Fixed widths of the request and response fields
    localparam int OPC_W   = 3;
    localparam int AMT_W   = 13;
    localparam int START_W = 12;
    localparam int RLEN_W  = 13;
    localparam int USED_W  = 13;

    // Request opcodes; codes 5 to 7 are ignored
    typedef enum logic [OPC_W-1:0] {
        OP_WR_RESERVE = 3'd0,
        OP_WR_COMMIT  = 3'd1,
        OP_RD_RESERVE = 3'd2,
        OP_RD_COMMIT  = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // execute the captured request and register the response
    } cmd_t;

endpackage

FILE: rtl/bbrm_ctrl.sv
// ----------------------------------------------------------------------------
// bbrm_ctrl
// Request sequencer: accepts one request, runs it through the datapath once
// the response register is free, and tracks response valid.
// ----------------------------------------------------------------------------
module bbrm_ctrl
    import bbrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Hold state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Wait until the response register drains
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EXEC)
        else $error("accepted request did not move to execute");

    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed request produced no response");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && !out_ready) |=>
            (state_reg == ST_EXEC && $stable(out_valid_reg)))
        else $error("response register overwritten while stalled");

    a_load_exec_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.exec))
        else $error("load and execute in the same cycle");
`endif

endmodule

FILE: rtl/bbrm_dpath.sv
// ----------------------------------------------------------------------------
// bbrm_dpath
// Region registers and response register of the bip buffer manager: captures
// a request, evaluates the reserve and commit rules and updates the regions.
// ----------------------------------------------------------------------------
module bbrm_dpath
    import bbrm_pkg::*;
#(
    parameter int CAPACITY = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [OPC_W-1:0]   opcode,
    input  logic [AMT_W-1:0]   amount,
    input  logic               exact,
    output logic               granted,
    output logic [START_W-1:0] region_start,
    output logic [RLEN_W-1:0]  region_length,
    output logic [USED_W-1:0]  used_bytes,
    output logic               data_ready
);

    // Offsets and lengths are wide enough for both the capacity and the amount
    localparam int CAP_BITS = $clog2(CAPACITY + 1);
    localparam int LEN_W    = (CAP_BITS > AMT_W) ? CAP_BITS : AMT_W;
    localparam logic [LEN_W:0] CAP_X = (LEN_W+1)'(CAPACITY);

    // Captured request
    logic [OPC_W-1:0] op_reg;
    logic [LEN_W-1:0] amt_reg;
    logic             exact_reg;

    // Region state
    logic [LEN_W-1:0] front_start_reg,    front_start_next;
    logic [LEN_W-1:0] front_length_reg,   front_length_next;
    logic [LEN_W-1:0] wrap_length_reg,    wrap_length_next;
    logic [LEN_W-1:0] pending_start_reg,  pending_start_next;
    logic [LEN_W-1:0] pending_length_reg, pending_length_next;
    logic             ready_flag_reg,     ready_flag_next;

    // Response
    logic               granted_reg, granted_next;
    logic [START_W-1:0] rstart_reg;
    logic [LEN_W-1:0]   rstart_next;
    logic [RLEN_W-1:0]  rlen_reg;
    logic [LEN_W-1:0]   rlen_next;
    logic [USED_W-1:0]  used_reg;

    // Write reserve evaluation
    logic [LEN_W:0]   front_end;
    logic [LEN_W:0]   tail_room;
    logic [LEN_W-1:0] head_gap;
    logic             wr_ok;
    logic [LEN_W-1:0] wr_start;
    logic [LEN_W-1:0] wr_len;

    // Commit and read helpers
    logic [LEN_W-1:0] commit_n;
    logic [LEN_W-1:0] rd_len;
    logic [LEN_W:0]   used_old;
    logic [LEN_W:0]   used_new;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            amt_reg   <= LEN_W'(amount);
            exact_reg <= exact;
        end
    end

    // Find the gap that a write reserve would take
    always_comb
    begin
        front_end = {1'b0, front_start_reg} + {1'b0, front_length_reg};
        tail_room = (CAP_X > front_end) ? (CAP_X - front_end) : '0;
        head_gap  = (front_start_reg > wrap_length_reg) ?
                    (front_start_reg - wrap_length_reg) : '0;
        wr_ok     = 1'b0;
        wr_start  = '0;
        wr_len    = '0;
        if (wrap_length_reg == '0)
        begin
            if (tail_room >= {1'b0, front_start_reg})
            begin
                wr_ok    = (tail_room != '0);
                wr_start = front_end[LEN_W-1:0];
                wr_len   = ({1'b0, amt_reg} < tail_room) ? amt_reg : tail_room[LEN_W-1:0];
            end
            else
            begin
                wr_ok    = (front_start_reg != '0);
                wr_start = '0;
                wr_len   = (amt_reg < front_start_reg) ? amt_reg : front_start_reg;
            end
        end
        else
        begin
            wr_start = wrap_length_reg;
            wr_len   = (amt_reg < head_gap) ? amt_reg : head_gap;
            wr_ok    = (wr_len != '0);
        end
    end

    // Apply the request to the regions
    always_comb
    begin
        front_start_next    = front_start_reg;
        front_length_next   = front_length_reg;
        wrap_length_next    = wrap_length_reg;
        pending_start_next  = pending_start_reg;
        pending_length_next = pending_length_reg;
        granted_next        = 1'b0;
        rstart_next         = '0;
        rlen_next           = '0;
        commit_n = (amt_reg < pending_length_reg) ? amt_reg : pending_length_reg;
        rd_len   = (amt_reg != '0 && front_length_reg > amt_reg) ? amt_reg : front_length_reg;
        case (op_reg)
            OP_WR_RESERVE:
            begin
                if (exact_reg && (!wr_ok || wr_len != amt_reg))
                begin
                    // Exact failure drops the pending reservation
                    pending_start_next  = '0;
                    pending_length_next = '0;
                end
                else if (wr_ok)
                begin
                    pending_start_next  = wr_start;
                    pending_length_next = wr_len;
                    granted_next        = 1'b1;
                    rstart_next         = wr_start;
                    rlen_next           = wr_len;
                end
            end
            OP_WR_COMMIT:
            begin
                granted_next = 1'b1;
                if (amt_reg != '0)
                begin
                    if (front_length_reg == '0 && wrap_length_reg == '0)
                    begin
                        front_start_next  = pending_start_reg;
                        front_length_next = commit_n;
                    end
                    else if ({1'b0, pending_start_reg} == front_end)
                    begin
                        front_length_next = front_length_reg + commit_n;
                    end
                    else
                    begin
                        wrap_length_next = wrap_length_reg + commit_n;
                    end
                end
                pending_start_next  = '0;
                pending_length_next = '0;
            end
            OP_RD_RESERVE:
            begin
                if (front_length_reg != '0 &&
                    (!exact_reg || amt_reg == '0 || rd_len == amt_reg))
                begin
                    granted_next = 1'b1;
                    rstart_next  = front_start_reg;
                    rlen_next    = rd_len;
                end
            end
            OP_RD_COMMIT:
            begin
                granted_next = 1'b1;
                if (amt_reg >= front_length_reg)
                begin
                    // Front region empties: promote the wrapped region
                    front_start_next  = '0;
                    front_length_next = wrap_length_reg;
                    wrap_length_next  = '0;
                end
                else
                begin
                    front_length_next = front_length_reg - amt_reg;
                    front_start_next  = front_start_reg + amt_reg;
                end
            end
            OP_CLEAR:
            begin
                granted_next        = 1'b1;
                front_start_next    = '0;
                front_length_next   = '0;
                wrap_length_next    = '0;
                pending_start_next  = '0;
                pending_length_next = '0;
            end
            default:
            begin
                granted_next = 1'b0;
            end
        endcase

        // Track data ready on used-byte transitions through zero
        used_old        = {1'b0, front_length_reg} + {1'b0, wrap_length_reg};
        used_new        = {1'b0, front_length_next} + {1'b0, wrap_length_next};
        ready_flag_next = ready_flag_reg;
        if (used_old == '0 && used_new != '0)
        begin
            ready_flag_next = 1'b1;
        end
        if (used_old != '0 && used_new == '0)
        begin
            ready_flag_next = 1'b0;
        end
    end

    // Advance region state on execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_start_reg    <= '0;
            front_length_reg   <= '0;
            wrap_length_reg    <= '0;
            pending_start_reg  <= '0;
            pending_length_reg <= '0;
            ready_flag_reg     <= 1'b0;
        end
        else if (cmd.exec)
        begin
            front_start_reg    <= front_start_next;
            front_length_reg   <= front_length_next;
            wrap_length_reg    <= wrap_length_next;
            pending_start_reg  <= pending_start_next;
            pending_length_reg <= pending_length_next;
            ready_flag_reg     <= ready_flag_next;
        end
    end

    // Register the response
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            granted_reg <= granted_next;
            rstart_reg  <= rstart_next[START_W-1:0];
            rlen_reg    <= rlen_next[RLEN_W-1:0];
            used_reg    <= used_new[USED_W-1:0];
        end
    end

    assign granted       = granted_reg;
    assign region_start  = rstart_reg;
    assign region_length = rlen_reg;
    assign used_bytes    = used_reg;
    assign data_ready    = ready_flag_reg;

endmodule

FILE: rtl/bipartite_buffer_region_manager_core.sv
// ----------------------------------------------------------------------------
// bipartite_buffer_region_manager_core
// Offset manager of a bip buffer: front, wrapped and pending write regions.
// ----------------------------------------------------------------------------
// Each request (write reserve, write commit, read reserve, read commit, clear)
// returns exactly one response carrying the grant, the granted region and the
// used-byte count and data-ready flag after the request. A request is first
// captured, then the datapath evaluates the region rules and updates the
// region registers; no new request is accepted until the captured one has
// executed, and execution waits while the response register is full. The response register lets
// one request be accepted while the previous response is still waiting.
// The byte storage itself lives outside the block; CAPACITY sets its size.
module bipartite_buffer_region_manager_core
    import bbrm_pkg::*;
#(
    parameter int CAPACITY = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OPC_W-1:0]   opcode,
    input  logic [AMT_W-1:0]   amount,
    input  logic               exact,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               granted,
    output logic [START_W-1:0] region_start,
    output logic [RLEN_W-1:0]  region_length,
    output logic [USED_W-1:0]  used_bytes,
    output logic               data_ready
);

    cmd_t cmd;

    // Sequence requests
    bbrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Hold and update the regions
    bbrm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (opcode),
        .amount        (amount),
        .exact         (exact),
        .granted       (granted),
        .region_start  (region_start),
        .region_length (region_length),
        .used_bytes    (used_bytes),
        .data_ready    (data_ready)
    );

endmodule
